// ===== rtl/sfp_pkg.sv =====
// shared types, codes and constant tables for the stomp frame parser
// no dependencies; used by every module of the block and by the checker
`timescale 1ns / 1ps

package sfp_pkg;

   // default sizes
   localparam int MAX_COMMAND_LEN = 12;
   localparam int LENGTH_BITS     = 32;

   // result channel packing
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 4;

   // event codes carried on tuser
   localparam logic [3:0] EV_FRAMING   = 4'd0;
   localparam logic [3:0] EV_CMD_BYTE  = 4'd1;
   localparam logic [3:0] EV_CMD_DONE  = 4'd2;
   localparam logic [3:0] EV_NAME_BYTE = 4'd3;
   localparam logic [3:0] EV_VALUE_BYTE = 4'd4;
   localparam logic [3:0] EV_HDR_DONE  = 4'd5;
   localparam logic [3:0] EV_BODY_BYTE = 4'd6;
   localparam logic [3:0] EV_FRAME_END = 4'd7;
   localparam logic [3:0] EV_ERROR     = 4'd8;

   // command codes
   localparam logic [3:0] CMD_NONE        = 4'd0;
   localparam logic [3:0] CMD_SEND        = 4'd1;
   localparam logic [3:0] CMD_SUBSCRIBE   = 4'd2;
   localparam logic [3:0] CMD_CONNECT     = 4'd3;
   localparam logic [3:0] CMD_UNSUBSCRIBE = 4'd4;
   localparam logic [3:0] CMD_BEGIN       = 4'd5;
   localparam logic [3:0] CMD_COMMIT      = 4'd6;
   localparam logic [3:0] CMD_CONNECTED   = 4'd7;
   localparam logic [3:0] CMD_ABORT       = 4'd8;
   localparam logic [3:0] CMD_ACK         = 4'd9;
   localparam logic [3:0] CMD_NACK        = 4'd10;
   localparam logic [3:0] CMD_DISCONNECT  = 4'd11;
   localparam logic [3:0] CMD_MESSAGE     = 4'd12;
   localparam logic [3:0] CMD_RECEIPT     = 4'd13;
   localparam logic [3:0] CMD_ERROR       = 4'd14;

   // special bytes
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_LF    = 8'h0A;
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_COLON = 8'h3A;
   localparam logic [7:0] BYTE_ZERO  = 8'h30;
   localparam logic [7:0] BYTE_NINE  = 8'h39;

   // command words, right-justified, first character in the highest used byte
   localparam int CMD_WORD_MAX = 11;
   localparam int CMD_ENTRIES  = 15;

   typedef struct packed {
      logic [8*CMD_WORD_MAX-1:0] word;
      logic [3:0]                len;
      logic [3:0]                code;
   } cmd_entry_type;

   localparam cmd_entry_type CMD_TABLE [CMD_ENTRIES] = '{
      '{88'("SEND"),        4'd4,  CMD_SEND},
      '{88'("SUBSCRIBE"),   4'd9,  CMD_SUBSCRIBE},
      '{88'("STOMP"),       4'd5,  CMD_CONNECT},
      '{88'("UNSUBSCRIBE"), 4'd11, CMD_UNSUBSCRIBE},
      '{88'("BEGIN"),       4'd5,  CMD_BEGIN},
      '{88'("COMMIT"),      4'd6,  CMD_COMMIT},
      '{88'("CONNECT"),     4'd7,  CMD_CONNECT},
      '{88'("CONNECTED"),   4'd9,  CMD_CONNECTED},
      '{88'("ABORT"),       4'd5,  CMD_ABORT},
      '{88'("ACK"),         4'd3,  CMD_ACK},
      '{88'("NACK"),        4'd4,  CMD_NACK},
      '{88'("DISCONNECT"),  4'd10, CMD_DISCONNECT},
      '{88'("MESSAGE"),     4'd7,  CMD_MESSAGE},
      '{88'("RECEIPT"),     4'd7,  CMD_RECEIPT},
      '{88'("ERROR"),       4'd5,  CMD_ERROR}
   };

   // the content-length header name
   localparam logic [4:0] LEN_NAME_SIZE = 5'd14;
   localparam logic [4:0] NAME_MISS     = 5'd31;
   localparam logic [7:0] LEN_NAME [14] = '{
      8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
      8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
   };

   // command buffer control from the parser
   typedef struct packed {
      logic       start;   // first byte of a new frame
      logic       store;   // further command byte
      logic [7:0] data;
   } cmd_ctl_type;

endpackage

// ===== rtl/sfp_cmd_buf.sv =====
// command line buffer and command word matcher
// depends on sfp_pkg for the command table and the control struct
`timescale 1ns / 1ps

module sfp_cmd_buf #(
   parameter int MAX_COMMAND_LEN = sfp_pkg::MAX_COMMAND_LEN
) (
   input  logic                clock,
   input  logic                reset,
   input  sfp_pkg::cmd_ctl_type ctl,
   output logic [3:0]          cmd_code
);

   localparam int CW = $clog2(MAX_COMMAND_LEN + 1);
   localparam int IW = $clog2(MAX_COMMAND_LEN);

   logic [7:0]    text_ff [MAX_COMMAND_LEN];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          long_ff;
   logic          long_in;
   logic          wr_en;
   logic [IW-1:0] wr_idx;

   always_comb begin
      count_in = count_ff;
      long_in  = long_ff;
      wr_en    = 1'b0;
      wr_idx   = count_ff[IW-1:0];
      if (ctl.start) begin
         count_in = CW'(1);
         long_in  = 1'b0;
         wr_en    = 1'b1;
         wr_idx   = '0;
      end else if (ctl.store) begin
         if (count_ff < CW'(MAX_COMMAND_LEN)) begin
            count_in = count_ff + CW'(1);
            wr_en    = 1'b1;
         end else begin
            long_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         long_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         long_ff  <= long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_ff[wr_idx] <= ctl.data;
      end
   end

   // parallel compare against every word, first entry wins
   always_comb begin
      logic hit;
      int   wlen;
      cmd_code = sfp_pkg::CMD_NONE;
      for (int k = sfp_pkg::CMD_ENTRIES - 1; k >= 0; k--) begin
         wlen = int'(sfp_pkg::CMD_TABLE[k].len);
         hit  = !long_ff && (count_ff == CW'(sfp_pkg::CMD_TABLE[k].len));
         for (int i = 0; i < sfp_pkg::CMD_WORD_MAX; i++) begin
            if (i < wlen) begin
               if (text_ff[i] != sfp_pkg::CMD_TABLE[k].word[8*(wlen-1-i) +: 8]) begin
                  hit = 1'b0;
               end
            end
         end
         if (hit) begin
            cmd_code = sfp_pkg::CMD_TABLE[k].code;
         end
      end
   end

endmodule

// ===== rtl/stomp_frame_parser.sv =====
// stomp frame parser: one byte in, one classified result out
// path: a byte accepted into the input register moves on to the result register and is presented on rsp
// throughput: one byte per cycle while rsp_tready is high; a stalled result holds the byte in the input register
// reset: synchronous, active high; parser returns to the start of a command,
//   per-frame state and the valid flags of both pipeline registers are cleared
// depends on sfp_pkg and sfp_cmd_buf
`timescale 1ns / 1ps

module stomp_frame_parser #(
   parameter int MAX_COMMAND_LEN = sfp_pkg::MAX_COMMAND_LEN,
   parameter int LENGTH_BITS     = sfp_pkg::LENGTH_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] byte_out, [11:8] command_code, [12] is_length_header,
   // [44:13] body_length, [45] length_known, [47:46] zero
   output logic [sfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [sfp_pkg::RSP_USER_W-1:0] rsp_tuser    // [3:0] event_res
);

   // parse phases
   localparam logic [3:0] PH_CMD_START   = 4'd0;
   localparam logic [3:0] PH_CMD         = 4'd1;
   localparam logic [3:0] PH_CMD_LF      = 4'd2;
   localparam logic [3:0] PH_NAME_START  = 4'd3;
   localparam logic [3:0] PH_NAME        = 4'd4;
   localparam logic [3:0] PH_VALUE_START = 4'd5;
   localparam logic [3:0] PH_VALUE       = 4'd6;
   localparam logic [3:0] PH_VALUE_LF    = 4'd7;
   localparam logic [3:0] PH_HDR_END_LF  = 4'd8;
   localparam logic [3:0] PH_BODY_START  = 4'd9;
   localparam logic [3:0] PH_BODY        = 4'd10;
   localparam logic [3:0] PH_FRAME_END   = 4'd11;
   localparam logic [3:0] PH_EOL         = 4'd12;
   localparam logic [3:0] PH_EOL_LF      = 4'd13;
   localparam logic [3:0] PH_ERROR       = 4'd14;

   localparam int LB = LENGTH_BITS;

   // ---------------------------------------------------------------
   // input register and pipeline control
   // ---------------------------------------------------------------
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff;
   logic       advance;      // byte moves from input register to result register

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   // ---------------------------------------------------------------
   // parser state
   // ---------------------------------------------------------------
   logic [3:0]    phase_ff, phase_in;
   logic [3:0]    cur_cmd_ff, cur_cmd_in;
   logic [4:0]    pos_ff, pos_in;          // progress through the length header name
   logic [LB-1:0] acc_ff, acc_in;          // content-length accumulator
   logic          digits_end_ff, digits_end_in;
   logic [LB-1:0] remain_ff, remain_in;    // body bytes still expected
   logic          seen_ff, seen_in;        // length captured for this frame

   logic [3:0]           ev;
   logic                 is_len;
   sfp_pkg::cmd_ctl_type ctl;
   sfp_pkg::cmd_ctl_type ctl_gated;
   logic [3:0]           matched_cmd;

   sfp_cmd_buf #(
      .MAX_COMMAND_LEN (MAX_COMMAND_LEN)
   ) u_cmd_buf (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_gated),
      .cmd_code (matched_cmd)
   );

   always_comb begin
      ctl_gated       = ctl;
      ctl_gated.start = ctl.start && advance;
      ctl_gated.store = ctl.store && advance;
   end

   // ---------------------------------------------------------------
   // helpers: header name match, value digits, body count
   // ---------------------------------------------------------------
   logic [7:0]    b;
   logic          capturing;
   logic          is_digit;
   logic [3:0]    digit;
   logic [LB-1:0] acc_base;
   logic          de_base;
   logic [LB+3:0] acc_wide;
   logic [LB-1:0] val_acc;
   logic          val_de;
   logic [4:0]    pos_base;
   logic [4:0]    name_pos;
   logic [LB-1:0] remain_dec;
   logic [3:0]    body_phase;
   logic          body_ok;

   assign b         = in_byte_ff;
   assign capturing = (pos_ff == sfp_pkg::LEN_NAME_SIZE) && !seen_ff;
   assign is_digit  = (b >= sfp_pkg::BYTE_ZERO) && (b <= sfp_pkg::BYTE_NINE);
   assign digit     = 4'(b - sfp_pkg::BYTE_ZERO);

   // value start clears the accumulator only for the length header
   always_comb begin
      if (phase_ff == PH_VALUE_START && capturing) begin
         acc_base = '0;
         de_base  = 1'b0;
      end else begin
         acc_base = acc_ff;
         de_base  = digits_end_ff;
      end
      // acc * 10 + digit, overflow into the top nibble means saturate
      acc_wide = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1) + (LB+4)'(digit);
      val_acc  = acc_base;
      val_de   = de_base;
      if (capturing && !de_base) begin
         if (!is_digit) begin
            val_de = 1'b1;
         end else if (acc_wide[LB+3:LB] != 4'b0) begin
            val_acc = '1;
         end else begin
            val_acc = acc_wide[LB-1:0];
         end
      end
   end

   // name byte: walk the content-length name, any miss parks at the miss code
   always_comb begin
      pos_base = (phase_ff == PH_NAME_START) ? 5'd0 : pos_ff;
      if (pos_base < sfp_pkg::LEN_NAME_SIZE &&
          b == sfp_pkg::LEN_NAME[pos_base[3:0]]) begin
         name_pos = pos_base + 5'd1;
      end else begin
         name_pos = sfp_pkg::NAME_MISS;
      end
   end

   // body byte with a known length counts down and stops at zero
   always_comb begin
      remain_dec = (remain_ff != '0) ? remain_ff - LB'(1) : remain_ff;
      if (seen_ff) begin
         body_phase = (remain_dec == '0) ? PH_FRAME_END : PH_BODY;
      end else begin
         body_phase = PH_BODY;
      end
      body_ok = cur_cmd_ff inside {sfp_pkg::CMD_SEND, sfp_pkg::CMD_MESSAGE,
                                   sfp_pkg::CMD_ERROR};
   end

   // ---------------------------------------------------------------
   // next state and event
   // ---------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      cur_cmd_in    = cur_cmd_ff;
      pos_in        = pos_ff;
      acc_in        = acc_ff;
      digits_end_in = digits_end_ff;
      remain_in     = remain_ff;
      seen_in       = seen_ff;
      ev            = sfp_pkg::EV_ERROR;
      is_len        = 1'b0;
      ctl.start     = 1'b0;
      ctl.store     = 1'b0;
      ctl.data      = b;

      case (phase_ff)
         PH_CMD_START: begin
            cur_cmd_in    = sfp_pkg::CMD_NONE;
            pos_in        = '0;
            acc_in        = '0;
            digits_end_in = 1'b0;
            remain_in     = '0;
            seen_in       = 1'b0;
            ctl.start     = 1'b1;
            phase_in      = PH_CMD;
            ev            = sfp_pkg::EV_CMD_BYTE;
         end
         PH_CMD, PH_CMD_LF: begin
            if (b == sfp_pkg::BYTE_LF) begin
               cur_cmd_in = matched_cmd;
               phase_in   = PH_NAME_START;
               ev         = sfp_pkg::EV_CMD_DONE;
            end else if (phase_ff == PH_CMD_LF) begin
               phase_in = PH_ERROR;
            end else if (b == sfp_pkg::BYTE_CR) begin
               phase_in = PH_CMD_LF;
               ev       = sfp_pkg::EV_FRAMING;
            end else begin
               ctl.store = 1'b1;
               ev        = sfp_pkg::EV_CMD_BYTE;
            end
         end
         PH_NAME_START, PH_NAME: begin
            if (phase_ff == PH_NAME_START && b == sfp_pkg::BYTE_CR) begin
               phase_in = PH_HDR_END_LF;
               ev       = sfp_pkg::EV_FRAMING;
            end else if (phase_ff == PH_NAME_START && b == sfp_pkg::BYTE_LF) begin
               phase_in = PH_BODY_START;
               ev       = sfp_pkg::EV_FRAMING;
            end else if (b == sfp_pkg::BYTE_COLON) begin
               pos_in   = pos_base;
               phase_in = PH_VALUE_START;
               ev       = sfp_pkg::EV_FRAMING;
            end else begin
               pos_in   = name_pos;
               phase_in = PH_NAME;
               ev       = sfp_pkg::EV_NAME_BYTE;
            end
         end
         PH_VALUE_START: begin
            if (b == sfp_pkg::BYTE_CR || b == sfp_pkg::BYTE_LF) begin
               phase_in = PH_ERROR;
            end else begin
               acc_in        = val_acc;
               digits_end_in = val_de;
               phase_in      = PH_VALUE;
               ev            = sfp_pkg::EV_VALUE_BYTE;
            end
         end
         PH_VALUE, PH_VALUE_LF: begin
            if (b == sfp_pkg::BYTE_LF) begin
               is_len = (pos_ff == sfp_pkg::LEN_NAME_SIZE);
               if (capturing) begin
                  seen_in   = 1'b1;
                  remain_in = acc_ff;
               end
               phase_in = PH_NAME_START;
               ev       = sfp_pkg::EV_HDR_DONE;
            end else if (phase_ff == PH_VALUE_LF) begin
               phase_in = PH_ERROR;
            end else if (b == sfp_pkg::BYTE_CR) begin
               phase_in = PH_VALUE_LF;
               ev       = sfp_pkg::EV_FRAMING;
            end else begin
               acc_in        = val_acc;
               digits_end_in = val_de;
               ev            = sfp_pkg::EV_VALUE_BYTE;
            end
         end
         PH_HDR_END_LF: begin
            if (b == sfp_pkg::BYTE_LF) begin
               phase_in = PH_BODY_START;
               ev       = sfp_pkg::EV_FRAMING;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_BODY_START, PH_BODY, PH_FRAME_END: begin
            if (b == sfp_pkg::BYTE_NUL) begin
               phase_in = PH_EOL;
               ev       = sfp_pkg::EV_FRAME_END;
            end else if (phase_ff == PH_FRAME_END) begin
               phase_in = PH_ERROR;
            end else if (phase_ff == PH_BODY_START &&
                         (!body_ok || (seen_ff && remain_ff == '0))) begin
               // refused body, or a zero length that needed the NUL at once
               phase_in = PH_ERROR;
            end else begin
               if (seen_ff) begin
                  remain_in = remain_dec;
               end
               phase_in = body_phase;
               ev       = sfp_pkg::EV_BODY_BYTE;
            end
         end
         PH_EOL: begin
            if (b == sfp_pkg::BYTE_CR) begin
               phase_in = PH_EOL_LF;
               ev       = sfp_pkg::EV_FRAMING;
            end else if (b == sfp_pkg::BYTE_LF) begin
               ev = sfp_pkg::EV_FRAMING;
            end else begin
               // any other byte opens the next frame
               cur_cmd_in    = sfp_pkg::CMD_NONE;
               pos_in        = '0;
               acc_in        = '0;
               digits_end_in = 1'b0;
               remain_in     = '0;
               seen_in       = 1'b0;
               ctl.start     = 1'b1;
               phase_in      = PH_CMD;
               ev            = sfp_pkg::EV_CMD_BYTE;
            end
         end
         PH_EOL_LF: begin
            if (b == sfp_pkg::BYTE_LF) begin
               phase_in = PH_EOL;
               ev       = sfp_pkg::EV_FRAMING;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         default: begin
            // sticky syntax error
            phase_in = PH_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_CMD_START;
         cur_cmd_ff    <= sfp_pkg::CMD_NONE;
         pos_ff        <= '0;
         acc_ff        <= '0;
         digits_end_ff <= 1'b0;
         remain_ff     <= '0;
         seen_ff       <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         cur_cmd_ff    <= cur_cmd_in;
         pos_ff        <= pos_in;
         acc_ff        <= acc_in;
         digits_end_ff <= digits_end_in;
         remain_ff     <= remain_in;
         seen_ff       <= seen_in;
      end
   end

   // ---------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------
   logic [63:0]                    acc_ext;
   logic [31:0]                    body_len;
   logic [sfp_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [sfp_pkg::RSP_USER_W-1:0] rsp_user_ff;

   assign acc_ext  = 64'(acc_in);
   assign body_len = seen_in ? acc_ext[31:0] : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= {2'b00, seen_in, body_len, is_len, cur_cmd_in, b};
         rsp_user_ff <= ev;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== rtl/sfp_checker.sv =====
// port-level checks for the stomp frame parser, attached by bind
// depends on sfp_pkg for event codes and port widths
`timescale 1ns / 1ps

module sfp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [sfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [sfp_pkg::RSP_USER_W-1:0] rsp_tuser
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // length header flag only on a completed header
   a_len_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> rsp_tuser == sfp_pkg::EV_HDR_DONE)
      else $error("length header flag outside header done");

   // no length value without a captured length
   a_len_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[45] |-> rsp_tdata[44:13] == 32'd0)
      else $error("body length without captured length");

   // frame end is always the nul byte
   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == sfp_pkg::EV_FRAME_END |-> rsp_tdata[7:0] == 8'h00)
      else $error("frame end on a non-nul byte");

endmodule

bind stomp_frame_parser sfp_checker u_sfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
